// ===== rtl/core/sp_pkg.sv =====
// Shared constants, the control bundle and the elaboration-time builder for the
// softplus correction ROM (ln(1 + exp(-t)) samples).
// No dependencies; used by sp_corr_rom, sp_interp and softplus_activation_core.
package sp_pkg;

    localparam int X_W            = 16;
    localparam int Y_W            = 16;
    localparam int POS_W          = X_W - 1;
    localparam int TABLE_ENTRIES_DEF = 256;
    localparam int FRAC_BITS_DEF  = 12;
    localparam int GUARD_BITS     = 8;
    localparam int SPAN_REAL      = 8;
    localparam int SPAN_LOG       = 3;   // log2 of SPAN_REAL
    localparam int WORK_BITS      = 30;
    localparam logic [63:0] ONE_W = 64'd1 << WORK_BITS;

    typedef struct packed {
        logic valid;
        logic in_span;
    } sp_ctl_t;

    // Restoring long division, used only while building the ROM.
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q;
        logic [63:0] r;
        q = '0;
        r = '0;
        for (int i = 63; i >= 0; i--) begin
            r = {r[62:0], num[i]};
            if (r >= den) begin
                r    = r - den;
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // exp(-r) for r in [0,1], Q.30
    function automatic logic [63:0] exp_neg_unit(input logic [63:0] r);
        logic [63:0] term;
        logic [63:0] even;
        logic [63:0] odd;
        term = ONE_W;
        even = ONE_W;
        odd  = '0;
        for (int i = 1; i <= 24; i++) begin
            term = udiv64((term * r) >> WORK_BITS, 64'(i));
            if ((i & 1) != 0)
                odd = odd + term;
            else
                even = even + term;
        end
        return even - odd;
    endfunction

    // ln(1+u) for u in [0,1], Q.30, as 2*atanh(u/(2+u))
    function automatic logic [63:0] ln_one_plus(input logic [63:0] u);
        logic [63:0] z;
        logic [63:0] z2;
        logic [63:0] pw;
        logic [63:0] s;
        z  = udiv64(u << WORK_BITS, (ONE_W << 1) + u);
        z2 = (z * z) >> WORK_BITS;
        pw = z;
        s  = '0;
        for (int i = 1; i <= 61; i += 2) begin
            s  = s + udiv64(pw, 64'(i));
            pw = (pw * z2) >> WORK_BITS;
        end
        return s << 1;
    endfunction

    // Sample k of the correction table, FRAC_BITS + GUARD_BITS fraction bits.
    function automatic logic [63:0] corr_entry(input logic [63:0] k, input int entries,
                                               input int frac);
        logic [63:0] em1;
        logic [63:0] t;
        logic [63:0] n;
        logic [63:0] u;
        logic [63:0] v;
        int          sh;
        em1 = exp_neg_unit(ONE_W);
        t   = udiv64((64'(SPAN_REAL) * k) << WORK_BITS, 64'(entries));
        n   = t >> WORK_BITS;
        u   = exp_neg_unit(t & (ONE_W - 64'd1));
        for (int j = 0; j < SPAN_REAL; j++) begin
            if (64'(j) < n)
                u = (u * em1) >> WORK_BITS;
        end
        v  = ln_one_plus(u);
        sh = WORK_BITS - frac - GUARD_BITS;
        return (v + (64'd1 << (sh - 1))) >> sh;
    endfunction

endpackage

// ===== rtl/core/sp_corr_rom.sv =====
// Correction ROM: TABLE_ENTRIES+1 samples of ln(1 + exp(-t)), two read ports,
// registered read data. Contents built at elaboration from sp_pkg.
module sp_corr_rom #(
    parameter int TABLE_ENTRIES = sp_pkg::TABLE_ENTRIES_DEF,
    parameter int FRAC_BITS     = sp_pkg::FRAC_BITS_DEF
) (
    input  logic                                      clk,
    input  logic                                      en,
    input  logic [$clog2(TABLE_ENTRIES+1)-1:0]        addr0,
    input  logic [$clog2(TABLE_ENTRIES+1)-1:0]        addr1,
    output logic [FRAC_BITS+sp_pkg::GUARD_BITS-1:0]   e0,
    output logic [FRAC_BITS+sp_pkg::GUARD_BITS-1:0]   e1
);

    localparam int TAB_W = FRAC_BITS + sp_pkg::GUARD_BITS;
    localparam int DEPTH = TABLE_ENTRIES + 1;

    logic [TAB_W-1:0] rom_mem [DEPTH];
    logic [TAB_W-1:0] e0_reg;
    logic [TAB_W-1:0] e1_reg;

    for (genvar k = 0; k < DEPTH; k++) begin : g_rom
        localparam logic [TAB_W-1:0] SAMPLE =
            TAB_W'(sp_pkg::corr_entry(64'(k), TABLE_ENTRIES, FRAC_BITS));
        assign rom_mem[k] = SAMPLE;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e0_reg <= rom_mem[addr0];
            e1_reg <= rom_mem[addr1];
        end
    end

    assign e0 = e0_reg;
    assign e1 = e1_reg;

endmodule

// ===== rtl/core/sp_interp.sv =====
// Interpolation and output stages: slope times remainder, corrected sample,
// guard-bit rounding, add of max(x,0), saturation and the output register.
// Depends on sp_pkg.
module sp_interp #(
    parameter int FRAC_BITS = sp_pkg::FRAC_BITS_DEF
) (
    input  logic                                              clk,
    input  logic                                              rst_n,
    input  sp_pkg::sp_ctl_t                                   ctl_a,
    input  logic [sp_pkg::POS_W-1:0]                          pos_a,
    input  logic [FRAC_BITS+sp_pkg::SPAN_LOG-1:0]             rem_a,
    input  logic [FRAC_BITS+sp_pkg::GUARD_BITS-1:0]           e0,
    input  logic [FRAC_BITS+sp_pkg::GUARD_BITS-1:0]           e1,
    output logic                                              take,
    output logic [sp_pkg::Y_W-1:0]                            y,
    output logic                                              y_valid,
    input  logic                                              y_ready
);

    localparam int SB     = FRAC_BITS + sp_pkg::SPAN_LOG;
    localparam int TAB_W  = FRAC_BITS + sp_pkg::GUARD_BITS;
    localparam int PROD_W = TAB_W + SB;
    localparam int R_W    = TAB_W + 1 - sp_pkg::GUARD_BITS;
    localparam int SUM_W  = (FRAC_BITS + 2 > sp_pkg::Y_W + 1) ? FRAC_BITS + 2 : sp_pkg::Y_W + 1;
    localparam logic [PROD_W:0] HALF_SPAN = (PROD_W+1)'(1) << (SB - 1);
    localparam logic [TAB_W:0]  HALF_LSB  = (TAB_W+1)'(1) << (sp_pkg::GUARD_BITS - 1);

    logic                      valid_b_reg;
    logic                      valid_c_reg;
    logic                      y_valid_reg;
    logic                      valid_b_next;
    logic                      valid_c_next;
    logic                      y_valid_next;
    logic                      take_c;
    logic                      take_o;

    logic [PROD_W-1:0]         prod_b_reg;
    logic [TAB_W-1:0]          e0_b_reg;
    logic [sp_pkg::POS_W-1:0]  pos_b_reg;
    logic                      span_b_reg;
    logic [TAB_W-1:0]          ci_c_reg;
    logic [sp_pkg::POS_W-1:0]  pos_c_reg;
    logic [sp_pkg::Y_W-1:0]    y_reg;

    logic [TAB_W:0]            diff;
    logic [TAB_W-1:0]          slope;
    logic [PROD_W-1:0]         prod_next;
    logic [PROD_W:0]           qsum;
    logic [TAB_W-1:0]          q;
    logic [TAB_W-1:0]          ci_next;
    logic [TAB_W:0]            rsum;
    logic [R_W-1:0]            corr;
    logic [SUM_W-1:0]          sum;
    logic [sp_pkg::Y_W-1:0]    y_next;

    assign take_o = !y_valid_reg || y_ready;
    assign take_c = !valid_c_reg || take_o;
    assign take   = !valid_b_reg || take_c;

    // samples fall with t; a rising pair is clamped to a flat segment
    always_comb
    begin
        diff      = {1'b0, e0} - {1'b0, e1};
        slope     = diff[TAB_W] ? '0 : diff[TAB_W-1:0];
        prod_next = PROD_W'(slope) * PROD_W'(rem_a);
    end

    always_comb
    begin
        qsum    = {1'b0, prod_b_reg} + HALF_SPAN;
        q       = qsum[SB +: TAB_W];
        ci_next = span_b_reg ? (e0_b_reg - q) : '0;
    end

    always_comb
    begin
        rsum   = {1'b0, ci_c_reg} + HALF_LSB;
        corr   = rsum[TAB_W:sp_pkg::GUARD_BITS];
        sum    = SUM_W'(pos_c_reg) + SUM_W'(corr);
        y_next = (|sum[SUM_W-1:sp_pkg::Y_W]) ? {sp_pkg::Y_W{1'b1}} : sum[sp_pkg::Y_W-1:0];
    end

    always_comb
    begin
        valid_b_next = take   ? ctl_a.valid : valid_b_reg;
        valid_c_next = take_c ? valid_b_reg : valid_c_reg;
        y_valid_next = take_o ? valid_c_reg : y_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_b_reg <= 1'b0;
            valid_c_reg <= 1'b0;
            y_valid_reg <= 1'b0;
        end
        else
        begin
            valid_b_reg <= valid_b_next;
            valid_c_reg <= valid_c_next;
            y_valid_reg <= y_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            prod_b_reg <= prod_next;
            e0_b_reg   <= e0;
            pos_b_reg  <= pos_a;
            span_b_reg <= ctl_a.in_span;
        end
        if (take_c)
        begin
            ci_c_reg  <= ci_next;
            pos_c_reg <= pos_b_reg;
        end
        if (take_o)
        begin
            y_reg <= y_next;
        end
    end

    assign y       = y_reg;
    assign y_valid = y_valid_reg;

`ifndef ASSERT_OFF
    a_hold_b: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_b_reg && !take_c) |=> (valid_b_reg && $stable(prod_b_reg) && $stable(e0_b_reg)))
        else $error("stage B changed while stalled");

    a_hold_c: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_c_reg && !take_o) |=> (valid_c_reg && $stable(ci_c_reg) && $stable(pos_c_reg)))
        else $error("stage C changed while stalled");

    a_move_c: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_c_reg && take_o) |=> y_valid_reg)
        else $error("beat lost between stage C and output");

    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !take |-> (valid_b_reg && valid_c_reg && y_valid_reg && !y_ready))
        else $error("input stalled with a free stage");
`endif

endmodule

// ===== rtl/core/softplus_activation_core.sv =====
// Softplus activation core: y = max(x,0) + ln(1 + exp(-|x|)), Q4.12 in and out.
// Depends on sp_pkg, sp_corr_rom and sp_interp.
//
// One beat in and one beat out per cycle, sustained while m_axis_tready is high;
// each beat passes ROM read, multiply, correction and output register in order.
// The rate is set by the two-port correction ROM, read once per beat for both
// neighboring samples. Stalls on the output fill the internal bubbles first, so
// s_axis_tready drops only when all four stages hold data. The ROM is a constant
// built at elaboration; no clearing pass after reset.
module softplus_activation_core #(
    parameter int TABLE_ENTRIES = sp_pkg::TABLE_ENTRIES_DEF,
    parameter int FRAC_BITS     = sp_pkg::FRAC_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [sp_pkg::X_W-1:0]    s_axis_tdata,   // [15:0] x
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [sp_pkg::Y_W-1:0]    m_axis_tdata    // [15:0] y
);

    localparam int SB         = FRAC_BITS + sp_pkg::SPAN_LOG;
    localparam int TAB_W      = FRAC_BITS + sp_pkg::GUARD_BITS;
    localparam int ADDR_W     = $clog2(TABLE_ENTRIES + 1);
    localparam int P_W        = sp_pkg::X_W + ADDR_W;
    localparam int SPAN_CODES = 1 << SB;
    localparam logic [ADDR_W-1:0] LAST_IDX = ADDR_W'(TABLE_ENTRIES);

    logic                        neg;
    logic [sp_pkg::X_W-1:0]      t;
    logic [sp_pkg::POS_W-1:0]    pos;
    logic [P_W-1:0]              p;
    logic [P_W-1:0]              idx_full;
    logic                        in_span;
    logic [ADDR_W-1:0]           idx;
    logic [ADDR_W-1:0]           idx1;

    logic                        take_a;
    logic                        take_b;
    logic                        valid_a_reg;
    logic                        valid_a_next;
    logic                        span_a_reg;
    logic [sp_pkg::POS_W-1:0]    pos_a_reg;
    logic [SB-1:0]               rem_a_reg;
    logic [TAB_W-1:0]            e0;
    logic [TAB_W-1:0]            e1;
    sp_pkg::sp_ctl_t             ctl_a;

    // |x| is 16 bits unsigned; x = -32768 maps to 32768
    always_comb
    begin
        neg      = s_axis_tdata[sp_pkg::X_W-1];
        t        = neg ? (-s_axis_tdata) : s_axis_tdata;
        pos      = neg ? '0 : s_axis_tdata[sp_pkg::POS_W-1:0];
        p        = P_W'(t) * P_W'(TABLE_ENTRIES);
        idx_full = p >> SB;
        in_span  = (32'(t) <= 32'(SPAN_CODES));
        idx      = in_span ? idx_full[ADDR_W-1:0] : '0;
        idx1     = (idx == LAST_IDX) ? idx : idx + ADDR_W'(1);
    end

    assign take_a        = !valid_a_reg || take_b;
    assign s_axis_tready = take_a;
    assign valid_a_next  = take_a ? s_axis_tvalid : valid_a_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_a_reg <= 1'b0;
        end
        else
        begin
            valid_a_reg <= valid_a_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_a)
        begin
            span_a_reg <= in_span;
            pos_a_reg  <= pos;
            rem_a_reg  <= p[SB-1:0];
        end
    end

    sp_corr_rom #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .FRAC_BITS     (FRAC_BITS)
    ) u_rom (
        .clk   (clk),
        .en    (take_a),
        .addr0 (idx),
        .addr1 (idx1),
        .e0    (e0),
        .e1    (e1)
    );

    assign ctl_a.valid   = valid_a_reg;
    assign ctl_a.in_span = span_a_reg;

    sp_interp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_interp (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl_a   (ctl_a),
        .pos_a   (pos_a_reg),
        .rem_a   (rem_a_reg),
        .e0      (e0),
        .e1      (e1),
        .take    (take_b),
        .y       (m_axis_tdata),
        .y_valid (m_axis_tvalid),
        .y_ready (m_axis_tready)
    );

endmodule

// ===== tb/tb_softplus_activation_core.sv =====
// Self-checking testbench for softplus_activation_core: x beats in, y beats out.
// It builds its own correction ROM and predicts every y. It depends only on sp_pkg
// and the core itself.
`timescale 1ns / 1ps

module tb_softplus_activation_core;

    localparam int X_W         = sp_pkg::X_W;
    localparam int Y_W         = sp_pkg::Y_W;
    localparam int GUARD_BITS  = sp_pkg::GUARD_BITS;
    localparam int WORK_BITS   = sp_pkg::WORK_BITS;
    localparam int SPAN_REAL   = sp_pkg::SPAN_REAL;
    localparam int N_ENTRIES   = sp_pkg::TABLE_ENTRIES_DEF;
    localparam int FRAC        = sp_pkg::FRAC_BITS_DEF;
    localparam int ROM_FRAC    = FRAC + GUARD_BITS;
    localparam int ROM_SHIFT   = WORK_BITS - ROM_FRAC;
    localparam logic [63:0] Q30_ONE    = 64'd1 << WORK_BITS;
    localparam logic [63:0] SPAN_CODES = 64'(SPAN_REAL) << FRAC;
    localparam int N_RANDOM    = 1000;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_WAIT  = 16;

    typedef struct {
        logic [X_W-1:0] x;
        logic [Y_W-1:0] y;
    } y_entry_t;

    logic           clk;
    logic           rst_n;
    logic           s_axis_tvalid = 1'b0;
    logic           s_axis_tready;
    logic [X_W-1:0] s_axis_tdata  = '0;
    logic           m_axis_tvalid;
    logic           m_axis_tready = 1'b0;
    logic [Y_W-1:0] m_axis_tdata;

    logic [63:0]    corr_rom [0:N_ENTRIES];
    logic [X_W-1:0] x_backlog [$];
    y_entry_t       y_expected [$];
    y_entry_t       y_head;

    int x_sent      = 0;
    int x_directed  = 0;
    int y_checked   = 0;
    int y_errors    = 0;
    int send_gap    = 0;
    int recv_stall  = 0;
    int quiet_count = 0;

    softplus_activation_core u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // exp(-r), r in [0,1], both Q.30
    function automatic logic [63:0] exp_neg_q30(input logic [63:0] r);
        logic [63:0] term;
        logic [63:0] evn;
        logic [63:0] odd;
        term = Q30_ONE;
        evn  = Q30_ONE;
        odd  = '0;
        for (int i = 1; i <= 24; i++)
        begin
            term = ((term * r) >> WORK_BITS) / 64'(i);
            if (i % 2 == 1)
                odd = odd + term;
            else
                evn = evn + term;
        end
        return evn - odd;
    endfunction

    function automatic logic [Y_W-1:0] softplus_expect(input logic [X_W-1:0] x);
        int          xs;
        logic [63:0] pos;
        logic [63:0] mag;
        logic [63:0] p;
        logic [63:0] idx;
        logic [63:0] rem;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] corr;
        logic [63:0] sum;
        xs   = $signed(x);
        pos  = (xs > 0) ? 64'(xs) : 64'd0;
        mag  = (xs < 0) ? 64'(-xs) : 64'(xs);
        corr = '0;
        if (mag <= SPAN_CODES)
        begin
            p   = mag * N_ENTRIES;
            idx = p / SPAN_CODES;
            rem = p % SPAN_CODES;
            if (idx > N_ENTRIES)
                idx = N_ENTRIES;
            lo = corr_rom[idx];
            hi = (idx < N_ENTRIES) ? corr_rom[idx + 1] : lo;
            if (hi > lo)
                hi = lo;
            corr = lo - ((lo - hi) * rem + SPAN_CODES / 2) / SPAN_CODES;
        end
        sum = pos + ((corr + (64'd1 << (GUARD_BITS - 1))) >> GUARD_BITS);
        if (sum > 64'hFFFF)
            sum = 64'hFFFF;
        return sum[Y_W-1:0];
    endfunction

    // mostly back-to-back, now and then a short gap, rarely a long one
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        else if (r < 95)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
    end

    // x driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            send_gap      <= 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                y_expected.push_back('{x: s_axis_tdata, y: softplus_expect(s_axis_tdata)});
                x_sent <= x_sent + 1;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (send_gap > 0)
                begin
                    send_gap      <= send_gap - 1;
                    s_axis_tvalid <= 1'b0;
                end
                else if (x_backlog.size() > 0)
                begin
                    s_axis_tdata  <= x_backlog.pop_front();
                    s_axis_tvalid <= 1'b1;
                    send_gap      <= idle_len();
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // y monitor and receiver stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            recv_stall    <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                // a beat with nothing pending compares against X and fails
                if (y_expected.size() > 0)
                    y_head = y_expected.pop_front();
                else
                    y_head = '{x: 'x, y: 'x};
                if (m_axis_tdata !== y_head.y)
                begin
                    if (y_errors < 10)
                        $display("%0t: y mismatch for x=%h: expected %h, got %h",
                                 $realtime, y_head.x, y_head.y, m_axis_tdata);
                    y_errors <= y_errors + 1;
                end
                y_checked <= y_checked + 1;
            end
            if (recv_stall > 0)
            begin
                recv_stall    <= recv_stall - 1;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                if ($urandom_range(0, 7) == 0)
                    recv_stall <= idle_len();
            end
        end
    end

    // watchdog: no beat on either side while work is outstanding
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (x_backlog.size() == 0 && !s_axis_tvalid && y_expected.size() == 0))
            quiet_count <= 0;
        else
            quiet_count <= quiet_count + 1;
        if (quiet_count >= STALL_LIMIT)
        begin
            $display("watchdog: no beat for %0d cycles, %0d y beats outstanding",
                     quiet_count, y_expected.size());
            $display("tb_softplus_activation_core: done, errors");
            $finish;
        end
    end

    initial
    begin
        logic [63:0] em1;
        logic [63:0] arg;
        logic [63:0] whole;
        logic [63:0] u;
        logic [63:0] z;
        logic [63:0] z2;
        logic [63:0] pw;
        logic [63:0] acc;
        int          xv;
        int          sel;

        // correction ROM: ln(1 + exp(-t)) sampled evenly over [0, SPAN_REAL]
        em1 = exp_neg_q30(Q30_ONE);
        for (int k = 0; k <= N_ENTRIES; k++)
        begin
            arg   = ((64'(SPAN_REAL) * 64'(k)) << WORK_BITS) / 64'(N_ENTRIES);
            whole = arg >> WORK_BITS;
            u     = exp_neg_q30(arg & (Q30_ONE - 64'd1));
            for (int j = 0; j < whole; j++)
                u = (u * em1) >> WORK_BITS;
            // ln(1+u) = 2*atanh(u/(2+u))
            z   = (u << WORK_BITS) / ((Q30_ONE << 1) + u);
            z2  = (z * z) >> WORK_BITS;
            pw  = z;
            acc = '0;
            for (int i = 1; i <= 61; i += 2)
            begin
                acc = acc + pw / 64'(i);
                pw  = (pw * z2) >> WORK_BITS;
            end
            corr_rom[k] = ((acc << 1) + (64'd1 << (ROM_SHIFT - 1))) >> ROM_SHIFT;
        end

        // directed: extremes, zero, the end of the span (x = -8.0), sample points
        x_backlog = '{16'h8000, 16'h7FFF, 16'h0000, 16'h0001, 16'hFFFF, 16'h8001,
                      16'h1000, 16'hF000, 16'h0080, 16'hFF80, 16'h007F, 16'hFF7F,
                      16'h0081, 16'hFF81, 16'h4000, 16'hC000, 16'h7F80, 16'h8080,
                      16'h5555, 16'hAAAA, 16'h0040, 16'hFFC0};
        x_directed = x_backlog.size();

        for (int n = 0; n < N_RANDOM; n++)
        begin
            sel = $urandom_range(0, 9);
            if (sel < 4)
                xv = $urandom_range(0, 65535);
            else if (sel < 7)
                xv = $urandom_range(0, 16383) - 8192;           // |x| <= 2, large correction
            else if (sel < 9)
                xv = ($urandom_range(0, 511) - 256) * 128 + $urandom_range(0, 4) - 2;
            else
                xv = $urandom_range(0, 1) ? $urandom_range(32700, 32767)
                                          : -$urandom_range(32700, 32768);
            x_backlog.push_back(xv[X_W-1:0]);
        end

        @(posedge rst_n);
        while (x_backlog.size() > 0 || s_axis_tvalid || y_expected.size() > 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("sent %0d x beats (%0d directed, rest random over the full range),",
                 x_sent, x_directed);
        $display("checked %0d y beats against the predicted softplus, %0d mismatches",
                 y_checked, y_errors);
        if (y_errors == 0 && y_expected.size() == 0)
            $display("tb_softplus_activation_core: done, clean");
        else
            $display("tb_softplus_activation_core: done, errors");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/sp_pkg.sv
rtl/core/sp_corr_rom.sv
rtl/core/sp_interp.sv
rtl/core/softplus_activation_core.sv
tb/tb_softplus_activation_core.sv
